// ===== hw/rtl/aptb_pkg.sv =====
// Package for the affine point transform with bounding box.
// Holds widths, register indexes, shared structs and the coordinate finishing function.
// No dependencies.
`timescale 1ns / 1ps

package aptb_pkg;

  localparam int CoordW = 32;
  localparam int CoefW = 24;
  localparam int ProdW = CoefW + CoordW;
  localparam int AccW = ProdW + 1;
  localparam int FracW = 16;
  localparam int LinW = AccW - FracW;
  localparam int SumW = LinW + 1;
  localparam int RoundBias = 2 ** (FracW - 1);
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIndexW-1:0] {
    REG_COEF_XX = 3'd0,
    REG_COEF_XY = 3'd1,
    REG_SHIFT_X = 3'd2,
    REG_COEF_YX = 3'd3,
    REG_COEF_YY = 3'd4,
    REG_SHIFT_Y = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoefW-1:0]  coef_xx;
    logic signed [CoefW-1:0]  coef_xy;
    logic signed [CoordW-1:0] shift_x;
    logic signed [CoefW-1:0]  coef_yx;
    logic signed [CoefW-1:0]  coef_yy;
    logic signed [CoordW-1:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic signed [ProdW-1:0] xx;
    logic signed [ProdW-1:0] xy;
    logic signed [ProdW-1:0] yx;
    logic signed [ProdW-1:0] yy;
    logic                    first;
  } prod_t;

  typedef struct packed {
    logic signed [CoordW-1:0] value;
    logic                     clipped;
  } coord_t;

  // Sum two products, round to nearest with ties up, add the translation and saturate.
  function automatic coord_t finish_coord(input logic signed [ProdW-1:0] pa,
                                          input logic signed [ProdW-1:0] pb,
                                          input logic signed [CoordW-1:0] sh);
    logic signed [AccW-1:0] acc;
    logic signed [LinW-1:0] lin;
    logic signed [SumW-1:0] sum;
    coord_t                 r;
    acc = AccW'(pa) + AccW'(pb) + AccW'(RoundBias);
    lin = LinW'(acc >>> FracW);
    sum = SumW'(lin) + SumW'(sh);
    if ((&sum[SumW-1:CoordW-1]) || !(|sum[SumW-1:CoordW-1])) begin
      r.value = sum[CoordW-1:0];
      r.clipped = 1'b0;
    end else begin
      r.value = sum[SumW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      r.clipped = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/affine_point_transform_bbox.sv =====
// Maps each Q16.16 point through a 2x3 affine matrix, saturates it to 32 bits and
// reports it with the running bounding box. A point is accepted every clock cycle
// unless a stalled result holds the pipeline, and its result passes through an input
// register, a register after the four 24x32 multipliers, and the result register that
// also holds the box corners.
// The box restarts at a point flagged as first; before any such point it grows from
// the zero box. Configuration writes take effect at once and belong between streams.
`timescale 1ns / 1ps

module affine_point_transform_bbox import aptb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,  // pt_x [31:0], pt_y [63:32]
  input  logic                 s_tuser,  // first_point
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [191:0]         m_tdata,  // out_x, out_y, box_min_x, box_min_y,
                                         // box_max_x, box_max_y, 32 bits each
  output logic                 m_tuser,  // saturated
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t                     cfg;
  logic                     prod_valid;
  logic                     prod_ready;
  prod_t                    prod;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic signed [CoordW-1:0] low_x;
  logic signed [CoordW-1:0] low_y;
  logic signed [CoordW-1:0] high_x;
  logic signed [CoordW-1:0] high_y;

  aptb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aptb_xform u_xform (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_pt_x    (s_tdata[31:0]),
    .in_pt_y    (s_tdata[63:32]),
    .in_first   (s_tuser),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  aptb_bbox u_bbox (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .shift_x    (cfg.shift_x),
    .shift_y    (cfg.shift_y),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_x      (out_x),
    .out_y      (out_y),
    .low_x      (low_x),
    .low_y      (low_y),
    .high_x     (high_x),
    .high_y     (high_y),
    .saturated  (m_tuser)
  );

  assign m_tdata = {high_y, high_x, low_y, low_x, out_y, out_x};

`ifndef SYNTHESIS
  a_box_holds_point: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (low_x <= out_x) && (out_x <= high_x) && (low_y <= out_y) && (out_y <= high_y))
    else $error("bounding box does not contain the current point");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_x == 32'sh7fffffff) || (out_x == 32'sh80000000) ||
                              (out_y == 32'sh7fffffff) || (out_y == 32'sh80000000))
    else $error("saturation flag set without a clamped coordinate");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid && !prod_valid)
    else $error("pipeline holds data after reset");

  a_stall_holds_box: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(low_x) && $stable(high_x) &&
                                $stable(low_y) && $stable(high_y))
    else $error("box state changed while the result was stalled");
`endif

endmodule

// ===== hw/rtl/aptb_cfg.sv =====
// Configuration register file for the affine point transform.
// Depends on aptb_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module aptb_cfg import aptb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx <= CoefW'(65536);
      cfg.coef_xy <= '0;
      cfg.shift_x <= '0;
      cfg.coef_yx <= '0;
      cfg.coef_yy <= CoefW'(65536);
      cfg.shift_y <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_XX: cfg.coef_xx <= cfg_data[CoefW-1:0];
        REG_COEF_XY: cfg.coef_xy <= cfg_data[CoefW-1:0];
        REG_SHIFT_X: cfg.shift_x <= cfg_data[CoordW-1:0];
        REG_COEF_YX: cfg.coef_yx <= cfg_data[CoefW-1:0];
        REG_COEF_YY: cfg.coef_yy <= cfg_data[CoefW-1:0];
        REG_SHIFT_Y: cfg.shift_y <= cfg_data[CoordW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aptb_xform.sv =====
// Input register and product register of the point transform pipeline.
// Depends on aptb_pkg for cfg_t and prod_t.
`timescale 1ns / 1ps

module aptb_xform import aptb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] in_pt_x,
  input  logic signed [CoordW-1:0] in_pt_y,
  input  logic                     in_first,
  input  cfg_t                     cfg,
  output logic                     prod_valid,
  input  logic                     prod_ready,
  output prod_t                    prod
);

  logic                     pt_valid;
  logic signed [CoordW-1:0] pt_x;
  logic signed [CoordW-1:0] pt_y;
  logic                     pt_first;
  logic                     advance;
  logic                     take;

  assign advance = pt_valid && (!prod_valid || prod_ready);
  assign in_ready = !pt_valid || advance;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (take) begin
      pt_valid <= 1'b1;
    end else if (advance) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pt_x <= in_pt_x;
      pt_y <= in_pt_y;
      pt_first <= in_first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= 1'b1;
    end else if (prod_ready) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod.xx <= ProdW'(cfg.coef_xx) * ProdW'(pt_x);
      prod.xy <= ProdW'(cfg.coef_xy) * ProdW'(pt_y);
      prod.yx <= ProdW'(cfg.coef_yx) * ProdW'(pt_x);
      prod.yy <= ProdW'(cfg.coef_yy) * ProdW'(pt_y);
      prod.first <= pt_first;
    end
  end

endmodule

// ===== hw/rtl/aptb_bbox.sv =====
// Rounding, translation, saturation, running bounding box and result register.
// Depends on aptb_pkg for prod_t, coord_t and finish_coord.
`timescale 1ns / 1ps

module aptb_bbox import aptb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     prod_valid,
  output logic                     prod_ready,
  input  prod_t                    prod,
  input  logic signed [CoordW-1:0] shift_x,
  input  logic signed [CoordW-1:0] shift_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CoordW-1:0] out_x,
  output logic signed [CoordW-1:0] out_y,
  output logic signed [CoordW-1:0] low_x,
  output logic signed [CoordW-1:0] low_y,
  output logic signed [CoordW-1:0] high_x,
  output logic signed [CoordW-1:0] high_y,
  output logic                     saturated
);

  coord_t cx;
  coord_t cy;
  logic   take;

  assign prod_ready = !out_valid || out_ready;
  assign take = prod_valid && prod_ready;

  always_comb begin
    cx = finish_coord(prod.xx, prod.xy, shift_x);
    cy = finish_coord(prod.yx, prod.yy, shift_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_x <= cx.value;
      out_y <= cy.value;
      saturated <= cx.clipped || cy.clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_x <= '0;
      low_y <= '0;
      high_x <= '0;
      high_y <= '0;
    end else if (take) begin
      if (prod.first) begin
        low_x <= cx.value;
        high_x <= cx.value;
        low_y <= cy.value;
        high_y <= cy.value;
      end else begin
        if (cx.value < low_x) begin
          low_x <= cx.value;
        end
        if (cx.value > high_x) begin
          high_x <= cx.value;
        end
        if (cy.value < low_y) begin
          low_y <= cy.value;
        end
        if (cy.value > high_y) begin
          high_y <= cy.value;
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for affine_point_transform_bbox: streams Q16.16 points through several matrix
// settings and checks every transformed point, saturation flag and running box.
// Depends on aptb_pkg and the affine_point_transform_bbox RTL.
`timescale 1ns / 1ps

module tb_top;
  import aptb_pkg::*;

  localparam logic [CoordW-1:0] MaxCoord = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] MinCoord = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [CfgIndexW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIndexW-1:0] RegSpareHi = 3'd7;
  localparam longint SumMax = 64'sd2147483647;
  localparam longint SumMin = -64'sd2147483648;
  localparam int StallLimit = 1000;

  typedef struct {
    logic [6*CoordW-1:0] fields;
    logic                sat;
  } point_result_t;

  class bbox_scoreboard;
    cfg_t matrix;
    logic signed [CoordW-1:0] lo_x, lo_y, hi_x, hi_y;
    point_result_t expected_boxes[$];
    string field_names[6] = '{"out_x", "out_y", "box_min_x", "box_min_y",
                              "box_max_x", "box_max_y"};
    int errors = 0;
    int points = 0;
    int clipped_count = 0;
    int restarts = 0;

    function new();
      matrix.coef_xx = 24'h010000;
      matrix.coef_xy = '0;
      matrix.shift_x = '0;
      matrix.coef_yx = '0;
      matrix.coef_yy = 24'h010000;
      matrix.shift_y = '0;
      lo_x = '0;
      lo_y = '0;
      hi_x = '0;
      hi_y = '0;
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_COEF_XX: matrix.coef_xx = data[CoefW-1:0];
        REG_COEF_XY: matrix.coef_xy = data[CoefW-1:0];
        REG_SHIFT_X: matrix.shift_x = data[CoordW-1:0];
        REG_COEF_YX: matrix.coef_yx = data[CoefW-1:0];
        REG_COEF_YY: matrix.coef_yy = data[CoefW-1:0];
        REG_SHIFT_Y: matrix.shift_y = data[CoordW-1:0];
        default: ;
      endcase
    endfunction

    // The products are exact in 64 bits, so rounding and clamping are done on the full sum.
    function void map_coord(input logic signed [CoordW-1:0] px, input logic signed [CoordW-1:0] py,
                            input logic signed [CoefW-1:0] ca, input logic signed [CoefW-1:0] cb,
                            input logic signed [CoordW-1:0] sh,
                            output logic signed [CoordW-1:0] v, inout logic clip);
      longint acc;
      longint total;
      acc = longint'(ca) * longint'(px) + longint'(cb) * longint'(py);
      total = ((acc + RoundBias) >>> FracW) + longint'(sh);
      if (total > SumMax) begin
        v = MaxCoord;
        clip = 1'b1;
      end else if (total < SumMin) begin
        v = MinCoord;
        clip = 1'b1;
      end else begin
        v = total[CoordW-1:0];
      end
    endfunction

    function void note_point(logic [CoordW-1:0] px, logic [CoordW-1:0] py, logic first);
      logic signed [CoordW-1:0] ox, oy;
      logic clip;
      point_result_t want;
      clip = 1'b0;
      map_coord(px, py, matrix.coef_xx, matrix.coef_xy, matrix.shift_x, ox, clip);
      map_coord(px, py, matrix.coef_yx, matrix.coef_yy, matrix.shift_y, oy, clip);
      if (first) begin
        lo_x = ox;
        hi_x = ox;
        lo_y = oy;
        hi_y = oy;
        restarts++;
      end else begin
        if (ox < lo_x) lo_x = ox;
        if (ox > hi_x) hi_x = ox;
        if (oy < lo_y) lo_y = oy;
        if (oy > hi_y) hi_y = oy;
      end
      want.fields = {hi_y, hi_x, lo_y, lo_x, oy, ox};
      want.sat = clip;
      expected_boxes = {expected_boxes, want};
      points++;
      if (clip) clipped_count++;
    endfunction

    function void check_result(logic [6*CoordW-1:0] got, logic got_sat);
      point_result_t want;
      if (expected_boxes.size() == 0) begin
        $error("Result transfer with no point outstanding: data %h", got);
        errors++;
        return;
      end
      want = expected_boxes.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[CoordW*i +: CoordW] !== want.fields[CoordW*i +: CoordW]) begin
          $error("%s: expected %0d, actual %0d", field_names[i],
                 $signed(want.fields[CoordW*i +: CoordW]), $signed(got[CoordW*i +: CoordW]));
          errors++;
        end
      end
      if (got_sat !== want.sat) begin
        $error("saturated: expected %0d, actual %0d", want.sat, got_sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  bbox_scoreboard sb = new();
  int tx_idle_pct = 18;
  int rx_idle_pct = 75;
  int rx_hold = 0;
  int settings = 1;

  affine_point_transform_bbox uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [CoordW-1:0] pick_coord();
    logic [CoordW-1:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: return r;
      4, 5, 6: return {{12{r[19]}}, r[19:0]};
      7: return MaxCoord;
      8: return MinCoord;
      default: return {{(CoordW-1){r[0]}}, 1'b1};
    endcase
  endfunction

  function automatic logic [CoefW-1:0] pick_coef();
    logic [CoefW-1:0] r;
    logic [CoefW-1:0] unit;
    r = CoefW'($urandom());
    unit = r[CoefW-1] ? 24'hFF0000 : 24'h010000;
    case ($urandom_range(7))
      0, 1: return r;
      2, 3, 4: return unit + {{12{r[11]}}, r[11:0]};
      5: return '0;
      6: return {1'b0, {(CoefW-1){1'b1}}};
      default: return {1'b1, {(CoefW-1){1'b0}}};
    endcase
  endfunction

  function automatic logic [CoordW-1:0] pick_shift();
    logic [CoordW-1:0] r;
    r = $urandom();
    case ($urandom_range(6))
      0, 1: return r;
      2, 3: return {{8{r[23]}}, r[23:0]};
      4: return '0;
      5: return MaxCoord;
      default: return MinCoord;
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Unused upper data bits of the coefficient writes carry noise, and a write to a spare
  // index comes last so that a decode error there would corrupt the new matrix.
  task automatic load_matrix(input logic [CoefW-1:0] xx, input logic [CoefW-1:0] xy,
                             input logic [CoordW-1:0] sx, input logic [CoefW-1:0] yx,
                             input logic [CoefW-1:0] yy, input logic [CoordW-1:0] sy);
    write_reg(REG_COEF_XX, {8'($urandom()), xx});
    write_reg(REG_COEF_XY, {8'($urandom()), xy});
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_COEF_YX, {8'($urandom()), yx});
    write_reg(REG_COEF_YY, {8'($urandom()), yy});
    write_reg(REG_SHIFT_Y, sy);
    write_reg($urandom_range(1) ? RegSpareLo : RegSpareHi, $urandom());
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_point(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
                            input logic first);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {py, px};
    s_tuser <= first;
    do @(posedge clk); while (!s_tready);
    sb.note_point(px, py, first);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly outlines that open with a first point, with a few stray flags mixed in.
  task automatic random_points(input int count);
    int run_left;
    logic first;
    run_left = 0;
    for (int n = 0; n < count; n++) begin
      first = 1'b0;
      if (run_left == 0) begin
        run_left = $urandom_range(20, 1);
        first = ($urandom_range(9) != 0);
      end else if ($urandom_range(19) == 0) begin
        first = 1'($urandom_range(1));
      end
      run_left--;
      send_point(pick_coord(), pick_coord(), first);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled = 0;
      else stalled++;
    end
    $display("Timeout: no transfer for %0d cycles", StallLimit);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset matrix is the identity; the box grows from the zero box until a first point.
    send_point('0, '0, 1'b0);
    send_point(32'h0005_8000, 32'hFFFD_0000, 1'b0);
    send_point(MaxCoord, MinCoord, 1'b0);
    send_point(MinCoord, MaxCoord, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    send_point(32'h0064_0000, 32'h00C8_0000, 1'b0);
    drain();

    // Extreme coefficients and shifts drive both coordinates of the extreme points into saturation.
    load_matrix(24'h7FFFFF, 24'h7FFFFF, MaxCoord, 24'h800000, 24'h800000, MinCoord);
    send_point(MaxCoord, MaxCoord, 1'b1);
    send_point(MinCoord, MinCoord, 1'b0);
    send_point('0, '0, 1'b0);
    send_point(pick_coord(), pick_coord(), 1'b0);
    drain();

    // The smallest coefficients put the sum exactly on a rounding tie.
    load_matrix(24'h000001, '0, '0, '0, 24'hFFFFFF, '0);
    send_point(32'h0000_8000, 32'h0000_8000, 1'b1);
    send_point(32'hFFFF_8000, 32'hFFFF_8000, 1'b0);
    send_point(32'h0001_8000, 32'h0000_7FFF, 1'b0);
    send_point(32'h0000_7FFF, 32'h0001_8000, 1'b0);
    drain();

    // The translation pushes the sum one step past either end of the range.
    load_matrix(24'h010000, '0, 32'h0000_0001, '0, 24'h010000, 32'hFFFF_FFFF);
    send_point(MaxCoord, MinCoord, 1'b1);
    send_point(32'h7FFF_FFFE, 32'h8000_0001, 1'b0);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 75 : 0;
      rx_idle_pct = (seg < 2) ? 75 : (seg < 4) ? 18 : 0;
      load_matrix(pick_coef(), pick_coef(), pick_shift(), pick_coef(), pick_coef(),
                  pick_shift());
      random_points(120);
      if (seg == 4) rx_hold = 64;
      else drain();
      random_points(138);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d points over %0d matrix settings: %0d saturated, %0d box restarts.",
             sb.points, settings, sb.clipped_count, sb.restarts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/aptb_pkg.sv
hw/rtl/aptb_cfg.sv
hw/rtl/aptb_xform.sv
hw/rtl/aptb_bbox.sv
hw/rtl/affine_point_transform_bbox.sv
tb/sv/tb_top.sv
